@@ rtl/rmfh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmfh_pkg
// shared types and codes for the recursive mutex lock unit
// ----------------------------------------------------------------------------
package rmfh_pkg;

    // default sizing, used as the defaults of the top level parameters
    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_MAX_DEPTH   = 255;

    // request codes
    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // result status codes
    localparam logic [2:0] ST_ACQ_FREE = 3'd0;
    localparam logic [2:0] ST_REENTER  = 3'd1;
    localparam logic [2:0] ST_QUEUED   = 3'd2;
    localparam logic [2:0] ST_LOWERED  = 3'd3;
    localparam logic [2:0] ST_FREED    = 3'd4;
    localparam logic [2:0] ST_HANDOFF  = 3'd5;
    localparam logic [2:0] ST_ERROR    = 3'd6;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the incoming request
        logic exec;     // resolve the latched request and load the result
    } t_ctrl_cmd;

endpackage

@@ rtl/rmfh_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmfh_ctrl
// request sequencer and result handshake for the lock unit
// ----------------------------------------------------------------------------
module rmfh_ctrl
    import rmfh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_ctrl_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_accept;

    // result slot is free, or drains at this same edge
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == S_EXEC) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = w_accept;
    assign o_cmd.exec    = (r_state == S_EXEC);

endmodule

@@ rtl/rmfh_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmfh_dp
// lock state, wait queue memory and result registers
// ----------------------------------------------------------------------------
module rmfh_dp
    import rmfh_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int MAX_DEPTH   = DEF_MAX_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl_cmd  i_cmd,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_command,
    input  logic [7:0] i_thread_id,
    output logic [2:0] o_status,
    output logic       o_owner_valid,
    output logic [7:0] o_owner_id,
    output logic [7:0] o_woken_id,
    output logic [7:0] o_hold_depth
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QW-1:0] PTR_LAST = QW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
    localparam logic [7:0]    DEPTH_MAX = 8'(MAX_DEPTH);

    // configuration
    logic r_mode;

    // latched request
    logic       r_cmd;
    logic [7:0] r_tid;

    // lock state
    logic          r_own_vld, n_own_vld;
    logic [7:0]    r_own_id,  n_own_id;
    logic [7:0]    r_depth,   n_depth;
    logic [QW-1:0] r_head,    n_head;
    logic [QW-1:0] r_tail,    n_tail;
    logic [CW-1:0] r_count,   n_count;

    // wait queue
    logic [7:0] r_queue [QUEUE_DEPTH];
    logic [7:0] r_rd_data;

    logic       w_holder;
    logic [7:0] w_limit;
    logic       w_push;
    logic [2:0] w_status;
    logic [7:0] w_woken;

    // result registers
    logic [2:0] r_status;
    logic       r_owner_valid;
    logic [7:0] r_owner_id;
    logic [7:0] r_woken_id;
    logic [7:0] r_hold_depth;

    assign w_holder = r_own_vld && (r_own_id == r_tid);
    assign w_limit  = r_mode ? DEPTH_MAX : 8'd1;

    always_comb begin
        n_own_vld = r_own_vld;
        n_own_id  = r_own_id;
        n_depth   = r_depth;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        w_push    = 1'b0;
        w_woken   = 8'd0;
        w_status  = ST_ERROR;
        if (r_cmd == CMD_ACQUIRE) begin
            if (w_holder) begin
                if (r_depth < w_limit) begin
                    n_depth  = r_depth + 8'd1;
                    w_status = ST_REENTER;
                end
            end else if (!r_own_vld) begin
                n_own_vld = 1'b1;
                n_own_id  = r_tid;
                n_depth   = 8'd1;
                w_status  = ST_ACQ_FREE;
            end else if (r_count != CNT_FULL) begin
                w_push   = 1'b1;
                n_tail   = (r_tail == PTR_LAST) ? '0 : r_tail + QW'(1);
                n_count  = r_count + CW'(1);
                w_status = ST_QUEUED;
            end
        end else begin
            if (w_holder) begin
                if (r_depth > 8'd1) begin
                    n_depth  = r_depth - 8'd1;
                    w_status = ST_LOWERED;
                end else if (r_count != '0) begin
                    // head entry was written at least one request earlier
                    w_woken  = r_rd_data;
                    n_own_id = r_rd_data;
                    n_depth  = 8'd1;
                    n_head   = (r_head == PTR_LAST) ? '0 : r_head + QW'(1);
                    n_count  = r_count - CW'(1);
                    w_status = ST_HANDOFF;
                end else begin
                    n_own_vld = 1'b0;
                    n_own_id  = 8'd0;
                    n_depth   = 8'd0;
                    w_status  = ST_FREED;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_own_vld <= 1'b0;
            r_own_id  <= 8'd0;
            r_depth   <= 8'd0;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_own_vld <= n_own_vld;
                r_own_id  <= n_own_id;
                r_depth   <= n_depth;
                r_head    <= n_head;
                r_tail    <= n_tail;
                r_count   <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= i_command;
            r_tid <= i_thread_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_push) begin
            r_queue[r_tail] <= r_tid;
        end
        r_rd_data <= r_queue[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status      <= w_status;
            r_owner_valid <= n_own_vld;
            r_owner_id    <= n_own_vld ? n_own_id : 8'd0;
            r_woken_id    <= w_woken;
            r_hold_depth  <= n_own_vld ? n_depth : 8'd0;
        end
    end

    assign o_status      = r_status;
    assign o_owner_valid = r_owner_valid;
    assign o_owner_id    = r_owner_id;
    assign o_woken_id    = r_woken_id;
    assign o_hold_depth  = r_hold_depth;

endmodule

@@ rtl/recursive_mutex_fifo_handoff.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recursive_mutex_fifo_handoff
// lock unit for one recursive mutex with first-in first-out hand-off
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  request   i_in_valid / o_in_ready    i_command, i_thread_id
//  result    o_out_valid / i_out_ready  o_status, o_owner_valid, o_owner_id,
//                                       o_woken_id, o_hold_depth
//  config    i_cfg_we                   i_cfg_wdata (recursive mode)
//
//  a request is latched, then resolved against the lock state and the
//  wait queue memory, whose head read is registered
//  one result per request; a new request is taken while the previous result
//  is being drained at the same edge
//  a stalled result holds the request side off until it is taken
//  synchronous active-low reset frees the lock and empties the queue;
//  queue entries are not cleared and are read only after being written
// ----------------------------------------------------------------------------
module recursive_mutex_fifo_handoff
    import rmfh_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int MAX_DEPTH   = DEF_MAX_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    // request transaction
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_command,
    input  logic [7:0] i_thread_id,
    // result transaction
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_status,
    output logic       o_owner_valid,
    output logic [7:0] o_owner_id,
    output logic [7:0] o_woken_id,
    output logic [7:0] o_hold_depth
);

    t_ctrl_cmd w_cmd;

    // sequencer: accepts a request, runs the resolve step, holds the result
    rmfh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // owner, depth, wait queue and result payload
    rmfh_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_DEPTH   (MAX_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_command     (i_command),
        .i_thread_id   (i_thread_id),
        .o_status      (o_status),
        .o_owner_valid (o_owner_valid),
        .o_owner_id    (o_owner_id),
        .o_woken_id    (o_woken_id),
        .o_hold_depth  (o_hold_depth)
    );

endmodule

@@ rtl/rmfh_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmfh_checker
// port-level checks on the result transaction of the lock unit
// ----------------------------------------------------------------------------
module rmfh_checker
    import rmfh_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_status,
    input logic       o_owner_valid,
    input logic [7:0] o_owner_id,
    input logic [7:0] o_woken_id,
    input logic [7:0] o_hold_depth
);

    // a free lock reports no owner and no depth
    a_free_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_owner_valid) |-> (o_owner_id == 8'd0 && o_hold_depth == 8'd0))
        else $error("free lock shows owner or depth");

    // hand-off makes the woken thread the owner at depth one
    a_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_HANDOFF)
            |-> (o_owner_valid && o_owner_id == o_woken_id && o_hold_depth == 8'd1))
        else $error("hand-off result inconsistent");

    // fresh acquire gives depth one, freeing leaves no owner
    a_acq_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_ACQ_FREE || o_status == ST_FREED))
            |-> (o_owner_valid == (o_status == ST_ACQ_FREE))
                && (o_hold_depth == ((o_status == ST_ACQ_FREE) ? 8'd1 : 8'd0)))
        else $error("acquire or free result inconsistent");

    // woken id stays zero unless a hand-off happened
    a_woken_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_HANDOFF) |-> (o_woken_id == 8'd0))
        else $error("woken id set without hand-off");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready)
            |=> (o_out_valid && $stable(o_status) && $stable(o_owner_id)
                 && $stable(o_hold_depth)))
        else $error("stalled result changed");

endmodule

bind recursive_mutex_fifo_handoff rmfh_checker u_rmfh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_owner_valid (o_owner_valid),
    .o_owner_id    (o_owner_id),
    .o_woken_id    (o_woken_id),
    .o_hold_depth  (o_hold_depth)
);
